// ===== design/bll_pkg.sv =====
`default_nettype none

package bll_pkg;

    // lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_TEXT = 4'b0010,
        MODE_BCOM = 4'b0100,
        MODE_LCOM = 4'b1000
    } mode_t;

    // result kinds
    localparam logic [2:0] K_TEXT      = 3'd0;
    localparam logic [2:0] K_OPEN      = 3'd1;
    localparam logic [2:0] K_CLOSE     = 3'd2;
    localparam logic [2:0] K_EOF       = 3'd3;
    localparam logic [2:0] K_UNCLOSED  = 3'd4;
    localparam logic [2:0] K_UNMATCHED = 3'd5;

    // characters with a meaning of their own
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // text settings
    localparam int          TEXT_BITS       = 16;
    localparam logic [15:0] TEXT_INDEX_MAX  = 16'hFFFF;
    localparam logic [15:0] KEEP_LIMIT_INIT = 16'd255;

    // result queue
    localparam int         RES_DEPTH    = 4;
    localparam int         RES_PTR_BITS = 2;
    localparam logic [2:0] RES_ROOM_MAX = 3'(RES_DEPTH - 2);

endpackage

`default_nettype wire

// ===== design/bracket_list_lexer_core.sv =====
// Streaming lexer for a parenthesis list format.
// Input channel: one request per character (ch) or end-of-file mark (at_end),
// taken when in_valid is high and in_stall is low.
// Output channel: one request per result (kind, ch_out, first_of_token,
// text_pos, line, last), taken when out_valid is high and out_stall is low;
// last marks the final result caused by one input request.
// Configuration: cfg_data sets the text keep limit on cfg_valid with
// cfg_ready, which is always high; write it only while the lexer is idle.
// Inputs are registered in the input stage, results in the result queue.
// Throughput: one input per cycle unless in_stall; lexer state is registered.
// End of file inside a bracket comment gives two results, which the
// single-result output port delivers one after the other.
// A four-entry result queue behind the lexing stage lets input keep flowing
// while the receiver stalls; in_stall rises once it holds more than two.
// Reset clears the queue, the input stage and the lexer state (line 1,
// no nesting) and restores the keep limit to 255.
`default_nettype none

module bracket_list_lexer_core
    import bll_pkg::*;
#(
    parameter int LINE_BITS  = 20,
    parameter int DEPTH_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input requests
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           ch,
    input  wire logic                 at_end,
    // result requests
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                kind,
    output logic [7:0]                ch_out,
    output logic                      first_of_token,
    output logic [TEXT_BITS-1:0]      text_pos,
    output logic [LINE_BITS-1:0]      line,
    output logic                      last,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TEXT_BITS-1:0] cfg_data
);

    localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]  LINE_ONE  = LINE_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    // configuration register
    logic [TEXT_BITS-1:0] keep_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= KEEP_LIMIT_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            keep_limit_reg <= cfg_data;
        end
    end

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_end_reg;
    logic       s1_adv;
    logic       in_take;

    logic [2:0] count_reg;

    assign s1_adv   = s1_valid_reg && (count_reg <= RES_ROOM_MAX);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_ch_reg  <= ch;
            s1_end_reg <= at_end;
        end
    end

    // lexer state
    mode_t                 mode_reg,   mode_next;
    logic [DEPTH_BITS-1:0] depth_reg,  depth_next;
    logic [LINE_BITS-1:0]  line_reg,   line_next;
    logic [LINE_BITS-1:0]  cstart_reg, cstart_next;
    logic [TEXT_BITS-1:0]  tidx_reg,   tidx_next;

    logic [LINE_BITS-1:0]  line_inc;
    logic [DEPTH_BITS-1:0] depth_dec;
    logic [TEXT_BITS-1:0]  tidx_eff;

    logic [1:0]           push_n;
    logic [2:0]           r0_kind;
    logic [7:0]           r0_ch;
    logic                 r0_first;
    logic [TEXT_BITS-1:0] r0_pos;
    logic [LINE_BITS-1:0] r0_line;

    assign line_inc  = (line_reg != LINE_MAX) ? line_reg + LINE_ONE : line_reg;
    assign depth_dec = (depth_reg != '0) ? depth_reg - DEPTH_ONE : depth_reg;
    assign tidx_eff  = (mode_reg == MODE_TEXT) ? tidx_reg : '0;

    // next state and results of the item in the input stage
    always_comb
    begin
        mode_next   = mode_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        cstart_next = cstart_reg;
        tidx_next   = tidx_reg;
        push_n      = 2'd0;
        r0_kind     = K_EOF;
        r0_ch       = 8'd0;
        r0_first    = 1'b0;
        r0_pos      = '0;
        r0_line     = line_reg;

        if (s1_adv)
        begin
            unique case (mode_reg)
                MODE_BCOM:
                begin
                    if (s1_end_reg)
                    begin
                        // unclosed comment, then end of file
                        r0_kind    = K_UNCLOSED;
                        r0_line    = cstart_reg;
                        push_n     = 2'd2;
                        mode_next  = MODE_IDLE;
                        depth_next = '0;
                    end
                    else if (s1_ch_reg == CH_LBRACK)
                    begin
                        if (depth_reg != DEPTH_MAX)
                        begin
                            depth_next = depth_reg + DEPTH_ONE;
                        end
                    end
                    else if (s1_ch_reg == CH_RBRACK)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else if (s1_ch_reg == CH_LF)
                    begin
                        line_next = line_inc;
                    end
                end
                MODE_LCOM:
                begin
                    if (s1_end_reg)
                    begin
                        push_n    = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (s1_ch_reg == CH_LF)
                    begin
                        line_next = line_inc;
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    if (s1_end_reg)
                    begin
                        push_n    = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        unique case (s1_ch_reg) inside
                            CH_SPACE, CH_TAB, CH_CR:
                            begin
                                mode_next = MODE_IDLE;
                            end
                            CH_LF:
                            begin
                                line_next = line_inc;
                                mode_next = MODE_IDLE;
                            end
                            CH_LPAREN:
                            begin
                                r0_kind   = K_OPEN;
                                push_n    = 2'd1;
                                mode_next = MODE_IDLE;
                            end
                            CH_RPAREN:
                            begin
                                r0_kind   = K_CLOSE;
                                push_n    = 2'd1;
                                mode_next = MODE_IDLE;
                            end
                            CH_LBRACK:
                            begin
                                mode_next   = MODE_BCOM;
                                depth_next  = DEPTH_ONE;
                                cstart_next = line_reg;
                            end
                            CH_RBRACK:
                            begin
                                r0_kind   = K_UNMATCHED;
                                push_n    = 2'd1;
                                mode_next = MODE_IDLE;
                            end
                            CH_HASH:
                            begin
                                mode_next = MODE_LCOM;
                            end
                            default:
                            begin
                                // text character
                                mode_next = MODE_TEXT;
                                r0_kind   = K_TEXT;
                                r0_ch     = s1_ch_reg;
                                r0_first  = (mode_reg != MODE_TEXT);
                                r0_pos    = tidx_eff;
                                if (tidx_eff < keep_limit_reg)
                                begin
                                    push_n = 2'd1;
                                end
                                tidx_next = (tidx_eff != TEXT_INDEX_MAX) ?
                                            tidx_eff + TEXT_BITS'(1) : tidx_eff;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            depth_reg  <= '0;
            line_reg   <= LINE_ONE;
            cstart_reg <= LINE_ONE;
            tidx_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            depth_reg  <= depth_next;
            line_reg   <= line_next;
            cstart_reg <= cstart_next;
            tidx_reg   <= tidx_next;
        end
    end

    // result queue
    logic [2:0]           kind_mem  [RES_DEPTH];
    logic [7:0]           ch_mem    [RES_DEPTH];
    logic                 first_mem [RES_DEPTH];
    logic [TEXT_BITS-1:0] pos_mem   [RES_DEPTH];
    logic [LINE_BITS-1:0] line_mem  [RES_DEPTH];
    logic                 last_mem  [RES_DEPTH];

    logic [RES_PTR_BITS-1:0] wr_ptr_reg;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg;
    logic [RES_PTR_BITS-1:0] wr_ptr_inc;
    logic                    pop;

    assign wr_ptr_inc = wr_ptr_reg + RES_PTR_BITS'(1);
    assign pop        = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            kind_mem[wr_ptr_reg]  <= r0_kind;
            ch_mem[wr_ptr_reg]    <= r0_ch;
            first_mem[wr_ptr_reg] <= r0_first;
            pos_mem[wr_ptr_reg]   <= r0_pos;
            line_mem[wr_ptr_reg]  <= r0_line;
            last_mem[wr_ptr_reg]  <= (push_n == 2'd1);
        end
        // second result is always the end-of-file token
        if (push_n == 2'd2)
        begin
            kind_mem[wr_ptr_inc]  <= K_EOF;
            ch_mem[wr_ptr_inc]    <= 8'd0;
            first_mem[wr_ptr_inc] <= 1'b0;
            pos_mem[wr_ptr_inc]   <= '0;
            line_mem[wr_ptr_inc]  <= line_reg;
            last_mem[wr_ptr_inc]  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_BITS'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_BITS'(1);
            end
            count_reg <= count_reg + {1'b0, push_n} - {2'b00, pop};
        end
    end

    // output port
    assign out_valid      = (count_reg != 3'd0);
    assign kind           = kind_mem[rd_ptr_reg];
    assign ch_out         = ch_mem[rd_ptr_reg];
    assign first_of_token = first_mem[rd_ptr_reg];
    assign text_pos       = pos_mem[rd_ptr_reg];
    assign line           = line_mem[rd_ptr_reg];
    assign last           = last_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== dv/tb_bracket_list_lexer_core.sv =====
`timescale 1ns / 100ps

module tb_bracket_list_lexer_core
    import bll_pkg::*;
();

    localparam int LINE_BITS  = 20;
    localparam int DEPTH_BITS = 16;
    localparam logic [LINE_BITS-1:0]  LINE_TOP  = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = '1;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           ch;
        logic                 first;
        logic [15:0]          pos;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } token_t;

    // expected token stream, tracks the lexer state on every accepted request
    class token_scoreboard;
        mode_t                 lex_mode;
        logic [DEPTH_BITS-1:0] depth;
        logic [LINE_BITS-1:0]  cur_line;
        logic [LINE_BITS-1:0]  comment_line;
        logic [15:0]           text_idx;
        logic [15:0]           keep_limit;
        token_t                expected_tokens[$];
        int                    errors;

        function new();
            lex_mode     = MODE_IDLE;
            depth        = '0;
            cur_line     = LINE_BITS'(1);
            comment_line = LINE_BITS'(1);
            text_idx     = '0;
            keep_limit   = KEEP_LIMIT_INIT;
            errors       = 0;
        endfunction

        function void set_keep_limit(logic [15:0] v);
            keep_limit = v;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function token_t make_token(logic [2:0] k, logic [7:0] c, logic f,
                                    logic [15:0] p, logic [LINE_BITS-1:0] ln);
            token_t t;
            t.kind  = k;
            t.ch    = c;
            t.first = f;
            t.pos   = p;
            t.line  = ln;
            t.last  = 1'b0;
            return t;
        endfunction

        function void bump_line();
            if (cur_line != LINE_TOP)
                cur_line++;
        endfunction

        function void lex_char(logic [7:0] c, logic e);
            token_t fresh[$];
            logic   first;
            first = 1'b0;
            case (lex_mode)
                MODE_BCOM:
                begin
                    if (e)
                    begin
                        fresh.push_back(make_token(K_UNCLOSED, '0, 1'b0, '0, comment_line));
                        fresh.push_back(make_token(K_EOF, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                        depth    = '0;
                    end
                    else if (c == CH_LBRACK)
                    begin
                        if (depth != DEPTH_TOP)
                            depth++;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        if (depth != 0)
                            depth--;
                        if (depth == 0)
                            lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_LF)
                        bump_line();
                end
                MODE_LCOM:
                begin
                    if (e)
                    begin
                        fresh.push_back(make_token(K_EOF, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_LF)
                    begin
                        bump_line();
                        lex_mode = MODE_IDLE;
                    end
                end
                default:
                begin
                    if (e)
                    begin
                        fresh.push_back(make_token(K_EOF, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
                    begin
                        if (c == CH_LF)
                            bump_line();
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_LPAREN)
                    begin
                        fresh.push_back(make_token(K_OPEN, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_RPAREN)
                    begin
                        fresh.push_back(make_token(K_CLOSE, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_LBRACK)
                    begin
                        lex_mode     = MODE_BCOM;
                        depth        = DEPTH_BITS'(1);
                        comment_line = cur_line;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        fresh.push_back(make_token(K_UNMATCHED, '0, 1'b0, '0, cur_line));
                        lex_mode = MODE_IDLE;
                    end
                    else if (c == CH_HASH)
                        lex_mode = MODE_LCOM;
                    else
                    begin
                        // text character, dropped past the keep limit
                        if (lex_mode != MODE_TEXT)
                        begin
                            lex_mode = MODE_TEXT;
                            text_idx = '0;
                            first    = 1'b1;
                        end
                        if (text_idx < keep_limit)
                            fresh.push_back(make_token(K_TEXT, c, first, text_idx, cur_line));
                        if (text_idx != TEXT_INDEX_MAX)
                            text_idx++;
                    end
                end
            endcase
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i])
                expected_tokens.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d line %0d",
                         $time, got.kind, got.line);
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("ch_out", want.ch, got.ch);
            compare_field("first_of_token", want.first, got.first);
            compare_field("text_pos", want.pos, got.pos);
            compare_field("line", want.line, got.line);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           ch = 8'h00;
    logic                 at_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           kind;
    logic [7:0]           ch_out;
    logic                 first_of_token;
    logic [15:0]          text_pos;
    logic [LINE_BITS-1:0] line;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [15:0]          cfg_data = 16'h0000;

    token_scoreboard sb = new();

    int  items_sent = 0;
    int  burst_left = 0;
    bit  hold_req   = 1'b0;
    int  hold_left  = 0;
    int  rx_style   = 0;
    int  style_left = 0;
    int  rx_phase   = 0;
    int  quiet      = 0;

    bracket_list_lexer_core #(
        .LINE_BITS  (LINE_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ch             (ch),
        .at_end         (at_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .ch_out         (ch_out),
        .first_of_token (first_of_token),
        .text_pos       (text_pos),
        .line           (line),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // accepted input requests feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.lex_char(ch, at_end);
    end

    // accepted results are checked in order
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_token('{kind, ch_out, first_of_token, text_pos, line, last});
    end

    // keep limit writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_keep_limit(cfg_data);
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.pending());
            $display("tb_bracket_list_lexer_core failed");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (style_left == 0)
            begin
                rx_style   = $urandom_range(0, 3);
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            rx_phase++;
            case (rx_style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 35);
                2: out_stall <= (rx_phase % 4 == 3);
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    function automatic logic [7:0] rand_text_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF ||
               b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACK ||
               b == CH_RBRACK || b == CH_HASH);
        return b;
    endfunction

    // sender gap, payload wanders while not valid
    task automatic pause_input(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            ch       <= 8'($urandom_range(0, 255));
            at_end   <= 1'($urandom_range(0, 1));
        end
    endtask

    // one input request, held until taken
    task automatic send_item(logic [7:0] c, logic e);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                pause_input($urandom_range(1, 12));
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        ch       <= c;
        at_end   <= e;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // drop valid and wait until the lexer has nothing in flight
    task automatic settle_input();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_keep_limit(logic [15:0] v);
        settle_input();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // short hand-picked stream: all kinds, comments, end-of-file cases
    task automatic directed_items();
        logic [8:0] seq [28];
        seq = '{
            {1'b0, CH_LPAREN}, {1'b0, 8'h00},    {1'b0, 8'hFF},     {1'b0, "a"},
            {1'b0, CH_SPACE},  {1'b0, CH_RPAREN}, {1'b0, CH_RBRACK}, {1'b0, "x"},
            {1'b0, CH_RBRACK}, {1'b0, "y"},       {1'b0, CH_LBRACK}, {1'b0, CH_LBRACK},
            {1'b0, CH_LF},     {1'b0, CH_RBRACK}, {1'b0, CH_RBRACK}, {1'b0, CH_HASH},
            {1'b0, CH_LPAREN}, {1'b0, CH_LF},     {1'b0, CH_TAB},    {1'b0, CH_CR},
            {1'b0, CH_LBRACK}, {1'b1, 8'h00},     {1'b1, 8'hFF},     {1'b0, CH_HASH},
            {1'b1, CH_LBRACK}, {1'b0, "z"},       {1'b1, CH_LPAREN}, {1'b0, CH_SPACE}
        };
        foreach (seq[i])
            send_item(seq[i][7:0], seq[i][8]);
    endtask

    // mostly well-formed token streams with random content, some noise
    task automatic random_phase(int n);
        int         stop;
        int         pick;
        int         len;
        int         lvl;
        int         r;
        logic [7:0] b;
        stop     = items_sent + n;
        hold_req = 1'b1;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 149) == 0)
                hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // text token, now and then a long one
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 300)
                                                   : $urandom_range(1, 10);
                repeat (len)
                    send_item(rand_text_char(), 1'b0);
            end
            else if (pick < 45)
            begin
                case ($urandom_range(0, 3))
                    0: send_item(CH_SPACE, 1'b0);
                    1: send_item(CH_TAB, 1'b0);
                    2: send_item(CH_CR, 1'b0);
                    default: send_item(CH_LF, 1'b0);
                endcase
            end
            else if (pick < 55)
                send_item(CH_LPAREN, 1'b0);
            else if (pick < 65)
                send_item(CH_RPAREN, 1'b0);
            else if (pick < 72)
            begin
                // nested bracket comment, sometimes left open
                lvl = 1;
                send_item(CH_LBRACK, 1'b0);
                repeat ($urandom_range(0, 12))
                begin
                    r = $urandom_range(0, 9);
                    if (r < 2)
                    begin
                        send_item(CH_LBRACK, 1'b0);
                        lvl++;
                    end
                    else if (r < 4 && lvl > 1)
                    begin
                        send_item(CH_RBRACK, 1'b0);
                        lvl--;
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_LBRACK || b == CH_RBRACK)
                            b = CH_LF;
                        send_item(b, 1'b0);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    repeat (lvl) send_item(CH_RBRACK, 1'b0);
            end
            else if (pick < 78)
            begin
                // line comment
                send_item(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 10))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_LF)
                        b = CH_LPAREN;
                    send_item(b, 1'b0);
                end
                send_item(CH_LF, 1'b0);
            end
            else if (pick < 82)
                send_item(CH_RBRACK, 1'b0);
            else if (pick < 85)
                send_item(8'($urandom_range(0, 255)), 1'b1);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();
        write_keep_limit(16'd1);
        random_phase(460);

        // widest keep limit
        write_keep_limit(16'hFFFF);
        random_phase(460);
        write_keep_limit(16'($urandom_range(2, 12)));
        random_phase(460);
        write_keep_limit(16'($urandom_range(1, 300)));
        random_phase(460);

        settle_input();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_bracket_list_lexer_core passed");
        else
            $display("tb_bracket_list_lexer_core failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bll_pkg.sv
design/bracket_list_lexer_core.sv
dv/tb_bracket_list_lexer_core.sv
